[hw/rtl/ptc_pkg.sv]
// ============================================================================
// ptc_pkg
// Shared types and constants of the pressure/temperature compensation unit.
// ============================================================================
package ptc_pkg;

    localparam int TFineOffset = 128000;
    localparam int PressBase   = 1048576;
    localparam int DivBits     = 64;

    localparam logic [63:0]        DivBias  = 64'h0000_8000_0000_0000;
    localparam logic signed [63:0] PressMin = -64'sd2147483648;
    localparam logic signed [63:0] PressMax = 64'sd2147483647;
    localparam logic signed [19:0] TempMin  = -20'sd65536;
    localparam logic signed [19:0] TempMax  = 20'sd65535;

    typedef enum logic [1:0] {
        CfgTemp   = 2'd0,
        CfgPressA = 2'd1,
        CfgPressB = 2'd2,
        CfgPressC = 2'd3
    } ptc_cfg_idx_t;

    typedef struct packed {
        logic [23:0] raw_temp;
        logic [23:0] raw_press;
    } ptc_in_t;

    typedef struct packed {
        logic signed [16:0] temp_centi;
        logic signed [31:0] press_q24_8;
        logic               div_error;
    } ptc_out_t;

    typedef struct packed {
        logic [47:0] tc;
        logic [47:0] pa;
        logic [47:0] pb;
        logic [47:0] pc;
    } ptc_coef_t;

    typedef struct packed {
        logic               valid;
        logic signed [16:0] temp_centi;
        logic [63:0]        num;
        logic [63:0]        den;
    } ptc_div_in_t;

    typedef struct packed {
        logic               valid;
        logic signed [16:0] temp_centi;
        logic [63:0]        quo;
        logic               zero;
    } ptc_div_out_t;

    typedef struct packed {
        logic signed [16:0] temp_centi;
        logic               neg;
        logic               zero;
    } ptc_div_side_t;

endpackage

[hw/rtl/ptc_front.sv]
// ============================================================================
// ptc_front
// Temperature path, fine-temperature term, pressure numerator and divisor.
// Ten register stages.
// ============================================================================
module ptc_front import ptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        ce,
    input  logic        in_valid,
    input  ptc_in_t     in_data,
    input  ptc_coef_t   coef,
    output ptc_div_in_t out_word
);

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;

    assign t1 = coef.tc[15:0];
    assign t2 = signed'(coef.tc[31:16]);
    assign t3 = signed'(coef.tc[47:32]);
    assign p1 = coef.pa[15:0];
    assign p2 = signed'(coef.pa[31:16]);
    assign p3 = signed'(coef.pa[47:32]);
    assign p4 = signed'(coef.pb[15:0]);
    assign p5 = signed'(coef.pb[31:16]);
    assign p6 = signed'(coef.pb[47:32]);

    logic [9:0] vld_reg;

    // stage 1
    logic [19:0]        adc_t, adc_p;
    logic signed [17:0] dx;
    logic signed [16:0] dt;
    logic signed [33:0] s1_x1a_reg, s1_dd_reg;
    logic [19:0]        s1_adcp_reg;
    // stage 2
    logic signed [33:0] x1_sh;
    logic signed [21:0] dd_sh;
    logic signed [22:0] s2_x1_reg;
    logic signed [37:0] s2_x2a_reg;
    logic [19:0]        s2_adcp_reg;
    // stage 3
    logic signed [37:0] x2_sh;
    logic signed [24:0] s3_tf_reg;
    logic [19:0]        s3_adcp_reg;
    // stage 4
    logic signed [27:0] t5;
    logic signed [27:0] tc_sh;
    logic signed [19:0] tc;
    logic signed [16:0] temp_next;
    logic signed [25:0] v1;
    logic signed [16:0] s4_temp_reg;
    logic signed [51:0] s4_v1sq_reg;
    logic signed [41:0] s4_v1p5_reg, s4_v1p2_reg;
    logic [19:0]        s4_adcp_reg;
    // stage 5
    logic signed [67:0] prod6, prod3;
    logic signed [16:0] s5_temp_reg;
    logic [63:0]        s5_a_reg, s5_b_reg;
    logic signed [41:0] s5_v1p5_reg, s5_v1p2_reg;
    logic [19:0]        s5_adcp_reg;
    // stage 6
    logic signed [63:0] b_sh;
    logic signed [16:0] s6_temp_reg;
    logic [63:0]        s6_v2_reg, s6_dsum_reg;
    logic [19:0]        s6_adcp_reg;
    // stage 7
    logic signed [16:0] s7_temp_reg;
    logic [63:0]        s7_v2_reg, s7_dprod_reg;
    logic [19:0]        s7_adcp_reg;
    // stage 8
    logic [20:0]        pdiff;
    logic signed [63:0] dps;
    logic signed [16:0] s8_temp_reg;
    logic [63:0]        s8_num0_reg, s8_den_reg;
    // stage 9
    logic signed [16:0] s9_temp_reg;
    logic [63:0]        s9_ns1_reg, s9_ns2_reg, s9_den_reg;
    // stage 10
    logic signed [16:0] s10_temp_reg;
    logic [63:0]        s10_num_reg, s10_den_reg;

    always_comb begin
        adc_t = in_data.raw_temp[23:4];
        adc_p = in_data.raw_press[23:4];
        dx    = signed'({1'b0, adc_t[19:3]}) - signed'({1'b0, t1, 1'b0});
        dt    = signed'({1'b0, adc_t[19:4]}) - signed'({1'b0, t1});
        x1_sh = s1_x1a_reg >>> 11;
        dd_sh = s1_dd_reg[33:12];
        x2_sh = s2_x2a_reg >>> 14;
        t5    = 28'(s3_tf_reg) * 28'sd5 + 28'sd128;
        tc_sh = t5 >>> 8;
        tc    = tc_sh[19:0];
        if (tc < TempMin) begin
            temp_next = 17'(TempMin);
        end else if (tc > TempMax) begin
            temp_next = 17'(TempMax);
        end else begin
            temp_next = tc[16:0];
        end
        v1    = 26'(s3_tf_reg) - 26'(TFineOffset);
        prod6 = s4_v1sq_reg * p6;
        prod3 = s4_v1sq_reg * p3;
        b_sh  = signed'(s5_b_reg) >>> 8;
        pdiff = 21'(PressBase) - {1'b0, s7_adcp_reg};
        dps   = signed'(s7_dprod_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[8:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_x1a_reg   <= dx * t2;
            s1_dd_reg    <= dt * dt;
            s1_adcp_reg  <= adc_p;

            s2_x1_reg    <= x1_sh[22:0];
            s2_x2a_reg   <= dd_sh * t3;
            s2_adcp_reg  <= s1_adcp_reg;

            s3_tf_reg    <= 25'(s2_x1_reg) + x2_sh[24:0];
            s3_adcp_reg  <= s2_adcp_reg;

            s4_temp_reg  <= temp_next;
            s4_v1sq_reg  <= v1 * v1;
            s4_v1p5_reg  <= v1 * p5;
            s4_v1p2_reg  <= v1 * p2;
            s4_adcp_reg  <= s3_adcp_reg;

            s5_temp_reg  <= s4_temp_reg;
            s5_a_reg     <= prod6[63:0];
            s5_b_reg     <= prod3[63:0];
            s5_v1p5_reg  <= s4_v1p5_reg;
            s5_v1p2_reg  <= s4_v1p2_reg;
            s5_adcp_reg  <= s4_adcp_reg;

            s6_temp_reg  <= s5_temp_reg;
            s6_v2_reg    <= s5_a_reg + (64'(s5_v1p5_reg) <<< 17) + (64'(p4) <<< 35);
            s6_dsum_reg  <= b_sh + (64'(s5_v1p2_reg) <<< 12) + DivBias;
            s6_adcp_reg  <= s5_adcp_reg;

            s7_temp_reg  <= s6_temp_reg;
            s7_v2_reg    <= s6_v2_reg;
            s7_dprod_reg <= s6_dsum_reg * p1;
            s7_adcp_reg  <= s6_adcp_reg;

            s8_temp_reg  <= s7_temp_reg;
            s8_num0_reg  <= ({43'b0, pdiff} << 31) - s7_v2_reg;
            s8_den_reg   <= 64'(dps >>> 33);

            // times 3125 = 2048 + 1024 + 32 + 16 + 4 + 1
            s9_temp_reg  <= s8_temp_reg;
            s9_ns1_reg   <= (s8_num0_reg << 11) + (s8_num0_reg << 10) + (s8_num0_reg << 5);
            s9_ns2_reg   <= (s8_num0_reg << 4) + (s8_num0_reg << 2) + s8_num0_reg;
            s9_den_reg   <= s8_den_reg;

            s10_temp_reg <= s9_temp_reg;
            s10_num_reg  <= s9_ns1_reg + s9_ns2_reg;
            s10_den_reg  <= s9_den_reg;
        end
    end

    assign out_word.valid      = vld_reg[9];
    assign out_word.temp_centi = s10_temp_reg;
    assign out_word.num        = s10_num_reg;
    assign out_word.den        = s10_den_reg;

endmodule

[hw/rtl/ptc_divider.sv]
// ============================================================================
// ptc_divider
// Pipelined signed 64-bit divider, truncating, one quotient bit per stage.
// ============================================================================
module ptc_divider import ptc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         ce,
    input  ptc_div_in_t  in_word,
    output ptc_div_out_t out_word
);

    logic [63:0]   rem_reg  [DivBits+1];
    logic [63:0]   qd_reg   [DivBits+1];
    logic [63:0]   dv_reg   [DivBits+1];
    ptc_div_side_t side_reg [DivBits+1];
    logic [DivBits:0] vld_reg;

    logic [63:0]   ua, ub;
    ptc_div_side_t side_next;
    logic          out_vld_reg;
    ptc_div_side_t out_side_reg;
    logic [63:0]   quo_reg;

    always_comb begin
        ua = in_word.num[63] ? (64'd0 - in_word.num) : in_word.num;
        ub = in_word.den[63] ? (64'd0 - in_word.den) : in_word.den;
        side_next.temp_centi = in_word.temp_centi;
        side_next.neg        = in_word.num[63] ^ in_word.den[63];
        side_next.zero       = (in_word.den == 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (ce) begin
            vld_reg[0] <= in_word.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= '0;
            qd_reg[0]   <= ua;
            dv_reg[0]   <= ub;
            side_reg[0] <= side_next;
        end
    end

    for (genvar k = 0; k < DivBits; k++) begin : g_step
        logic [64:0] sh;
        logic [64:0] diff;
        logic        fit;

        assign sh   = {rem_reg[k], qd_reg[k][63]};
        assign diff = sh - {1'b0, dv_reg[k]};
        assign fit  = !diff[64];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (ce) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k+1]  <= fit ? diff[63:0] : sh[63:0];
                qd_reg[k+1]   <= {qd_reg[k][62:0], fit};
                dv_reg[k+1]   <= dv_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            out_vld_reg <= vld_reg[DivBits];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_side_reg <= side_reg[DivBits];
            quo_reg      <= side_reg[DivBits].neg ? (64'd0 - qd_reg[DivBits])
                                                  : qd_reg[DivBits];
        end
    end

    assign out_word.valid      = out_vld_reg;
    assign out_word.temp_centi = out_side_reg.temp_centi;
    assign out_word.quo        = quo_reg;
    assign out_word.zero       = out_side_reg.zero;

endmodule

[hw/rtl/ptc_post.sv]
// ============================================================================
// ptc_post
// Second-order pressure correction, offset and saturation. Four stages; the
// final result is combinational from the last stage.
// ============================================================================
module ptc_post import ptc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         ce,
    input  ptc_div_out_t in_word,
    input  ptc_coef_t    coef,
    output logic         out_valid,
    output ptc_out_t     out_data
);

    logic signed [15:0] p7, p8, p9;

    assign p7 = signed'(coef.pc[15:0]);
    assign p8 = signed'(coef.pc[31:16]);
    assign p9 = signed'(coef.pc[47:32]);

    logic [3:0] vld_reg;

    logic signed [63:0] q_in, ps;
    logic signed [16:0] s1_temp_reg, s2_temp_reg, s3_temp_reg, s4_temp_reg;
    logic               s1_zero_reg, s2_zero_reg, s3_zero_reg, s4_zero_reg;
    logic [63:0]        s1_q_reg, s2_q_reg, s3_q_reg;
    logic [63:0]        s1_ps_reg, s1_m1_reg, s1_x2p_reg;
    logic [63:0]        s2_ll_reg;
    logic [31:0]        s2_c1_reg, s2_c2_reg;
    logic [63:0]        s2_x2_reg, s3_x2_reg;
    logic [63:0]        prod;
    logic [63:0]        s3_x1_reg;
    logic [63:0]        s4_sum_reg;
    logic signed [63:0] res;

    always_comb begin
        q_in = signed'(in_word.quo);
        ps   = q_in >>> 13;
        prod = s2_ll_reg + {32'(s2_c1_reg + s2_c2_reg), 32'b0};
        res  = (signed'(s4_sum_reg) >>> 8) + (64'(p7) <<< 4);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[2:0], in_word.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_temp_reg <= in_word.temp_centi;
            s1_zero_reg <= in_word.zero;
            s1_q_reg    <= in_word.quo;
            s1_ps_reg   <= ps;
            s1_m1_reg   <= p9 * ps;
            s1_x2p_reg  <= p8 * q_in;

            // low 64 bits of m1 * ps from 32x32 partial products
            s2_temp_reg <= s1_temp_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_q_reg    <= s1_q_reg;
            s2_ll_reg   <= s1_m1_reg[31:0] * s1_ps_reg[31:0];
            s2_c1_reg   <= 32'(s1_m1_reg[63:32] * s1_ps_reg[31:0]);
            s2_c2_reg   <= 32'(s1_m1_reg[31:0] * s1_ps_reg[63:32]);
            s2_x2_reg   <= signed'(s1_x2p_reg) >>> 19;

            s3_temp_reg <= s2_temp_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_q_reg    <= s2_q_reg;
            s3_x1_reg   <= signed'(prod) >>> 25;
            s3_x2_reg   <= s2_x2_reg;

            s4_temp_reg <= s3_temp_reg;
            s4_zero_reg <= s3_zero_reg;
            s4_sum_reg  <= s3_q_reg + s3_x1_reg + s3_x2_reg;
        end
    end

    always_comb begin
        out_data.temp_centi = s4_temp_reg;
        out_data.div_error  = s4_zero_reg;
        if (s4_zero_reg) begin
            out_data.press_q24_8 = '0;
        end else if (res < PressMin) begin
            out_data.press_q24_8 = 32'(PressMin);
        end else if (res > PressMax) begin
            out_data.press_q24_8 = 32'(PressMax);
        end else begin
            out_data.press_q24_8 = res[31:0];
        end
    end

    assign out_valid = vld_reg[3];

endmodule

[hw/rtl/pressure_temp_compensation_unit.sv]
// ============================================================================
// pressure_temp_compensation_unit
// Integer barometric compensation: raw temperature and pressure words in,
// temperature in 0.01 degree and Q24.8 pressure out.
// ============================================================================
// Usage:
//   s_ channel takes one word of raw_temp/raw_press (low 4 bits ignored).
//   m_ channel returns temp_centi, press_q24_8 and div_error per input word.
//   cfg_we/cfg_index/cfg_wdata write the four 48-bit coefficient registers;
//   write only while no word is in flight.
// Pipeline: 10 front stages, 66 divider stages, 4 correction stages and
//   1 output register.
// Throughput: one word per cycle while m_ready does not stall the pipeline;
//   the pipelined 64-bit divider, one quotient bit per stage, sets the depth.
// Reset: aresetn low clears all valid bits and the coefficient registers.
// Stall: when m_ready is low with a result held, the whole pipeline freezes
//   and s_ready drops; nothing is lost or repeated.
// ============================================================================
module pressure_temp_compensation_unit import ptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ptc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ptc_out_t    m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);

    ptc_coef_t    coef_reg;
    logic         ce;
    ptc_div_in_t  front_word;
    ptc_div_out_t div_word;
    logic         post_valid;
    ptc_out_t     post_data;
    logic         m_valid_reg;
    ptc_out_t     m_data_reg;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_we) begin
            unique case (ptc_cfg_idx_t'(cfg_index))
                CfgTemp:   coef_reg.tc <= cfg_wdata;
                CfgPressA: coef_reg.pa <= cfg_wdata;
                CfgPressB: coef_reg.pb <= cfg_wdata;
                CfgPressC: coef_reg.pc <= cfg_wdata;
            endcase
        end
    end

    ptc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_valid),
        .in_data  (s_data),
        .coef     (coef_reg),
        .out_word (front_word)
    );

    ptc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_word  (front_word),
        .out_word (div_word)
    );

    ptc_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_word   (div_word),
        .coef      (coef_reg),
        .out_valid (post_valid),
        .out_data  (post_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= post_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_data_reg <= post_data;
        end
    end

`ifndef SYNTHESIS
    a_err_zero_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.div_error |-> m_data.press_q24_8 == 32'sd0)
        else $error("pressure not zero on divisor error");

    a_coef_reset: assert property (@(posedge aclk)
        !aresetn |=> coef_reg == '0)
        else $error("coefficients not cleared by reset");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(front_word.valid) && $stable(div_word.valid)
                && $stable(post_valid))
        else $error("pipeline moved during stall");

    a_cfg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_we |=> $stable(coef_reg))
        else $error("coefficients changed without a write");
`endif

endmodule
